// ===== sv/phase_vocoder_bin_rotator_macros.svh =====
// Assertion macros for the phase vocoder bin rotator.
// Used by the top level only.
`ifndef PHASE_VOCODER_BIN_ROTATOR_MACROS_SVH
`define PHASE_VOCODER_BIN_ROTATOR_MACROS_SVH
// assert that a implies b on every edge
`define PVR_ASSERT_IMPL(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("pvr check failed");
// assert that a implies b in the next cycle
`define PVR_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("pvr check failed");
`endif

// ===== sv/pvr_pkg.sv =====
// Package for the phase vocoder bin rotator: widths, constants, helpers.
// No dependencies.
`timescale 1ns / 1ps
package pvr_pkg;
	localparam int unsigned Bins = 1024;
	localparam int unsigned IdxW = 10;
	localparam int unsigned AddrW = $clog2(Bins);
	localparam logic signed [31:0] K0225 = 32'sd483183821;
	localparam logic [23:0] Q24Quarter = 24'd4194304;

	typedef struct packed {
		logic [IdxW-1:0] bin_index;
		logic signed [31:0] bin_real;
		logic signed [31:0] bin_imag;
		logic signed [31:0] analysis_phase;
		logic signed [31:0] phase_advance;
		logic refresh_rotation;
	} pvr_in_t;

	typedef struct packed {
		logic signed [31:0] out_real;
		logic signed [31:0] out_imag;
		logic signed [23:0] synth_phase;
		logic phase_valid;
	} pvr_out_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

// ===== sv/pvr_if.sv =====
// Valid/ready channel interfaces for the rotator.
// Depends on pvr_pkg.
`timescale 1ns / 1ps
interface pvr_in_if;
	logic valid;
	logic ready;
	pvr_pkg::pvr_in_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pvr_out_if;
	logic valid;
	logic ready;
	pvr_pkg::pvr_out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/pvr_ram.sv =====
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pvr_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic re,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

// ===== sv/pvr_sine.sv =====
// Pipelined parabolic sine of a Q0.24 phase, scaled by gain; 4 stages.
// Depends on pvr_pkg.
`timescale 1ns / 1ps
module pvr_sine (
	input logic clk,
	input logic en,
	input logic signed [23:0] phase,
	input logic [31:0] gain,
	output logic signed [31:0] rot
);
	import pvr_pkg::*;
	logic signed [24:0] ap;
	logic signed [48:0] par44;
	logic signed [33:0] par30_s1;
	logic signed [33:0] apar;
	logic signed [68:0] corr60;
	logic signed [38:0] corr30_s2;
	logic signed [33:0] par_s2;
	logic signed [71:0] cprod;
	logic signed [34:0] sine_s3;
	logic signed [67:0] sprod;
	logic signed [67:0] srnd;

	always_comb begin
		ap = phase[23] ? -25'(phase) : 25'(phase);
		par44 = 49'(phase) * 49'sd8388608 - 49'(phase) * 49'(ap);
		apar = par30_s1[33] ? -par30_s1 : par30_s1;
		corr60 = 69'(par30_s1) * 69'(apar) - 69'(par30_s1) * 69'sd1073741824;
		cprod = 72'(corr30_s2) * 72'(K0225) + 72'sd1073741824;
		sprod = 68'(sine_s3) * 68'($signed({1'b0, gain})) + 68'sd536870912;
		srnd = sprod >>> 30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			par30_s1 <= 34'((par44 + 49'sd8192) >>> 14);
			corr30_s2 <= 39'((corr60 + 69'sd536870912) >>> 30);
			par_s2 <= par30_s1;
			sine_s3 <= 35'(par_s2) + 35'(cprod >>> 31);
			rot <= sat32(66'(srnd));
		end
	end
endmodule

// ===== sv/pvr_rotate.sv =====
// Complex multiply of a bin by its rotation, or gain scaling for bin 0.
// Two stages. Depends on pvr_pkg.
`timescale 1ns / 1ps
module pvr_rotate (
	input logic clk,
	input logic en,
	input logic signed [31:0] re_in,
	input logic signed [31:0] im_in,
	input logic signed [31:0] c,
	input logic signed [31:0] s,
	input logic [31:0] gain,
	input logic is_zero,
	output logic signed [31:0] re_out,
	output logic signed [31:0] im_out
);
	import pvr_pkg::*;
	logic signed [63:0] rc_s1, ms_s1, rs_s1, mc_s1;
	logic signed [64:0] rg_s1, mg_s1;
	logic zero_s1;
	logic signed [65:0] sre, sim, gre, gim;

	always_comb begin
		sre = (66'(rc_s1) - 66'(ms_s1) + 66'sd1073741824) >>> 31;
		sim = (66'(rs_s1) + 66'(mc_s1) + 66'sd1073741824) >>> 31;
		gre = (66'(rg_s1) + 66'sd1073741824) >>> 31;
		gim = (66'(mg_s1) + 66'sd1073741824) >>> 31;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rc_s1 <= re_in * c;
			ms_s1 <= im_in * s;
			rs_s1 <= re_in * s;
			mc_s1 <= im_in * c;
			rg_s1 <= 65'(re_in) * 65'($signed({1'b0, gain}));
			mg_s1 <= 65'(im_in) * 65'($signed({1'b0, gain}));
			zero_s1 <= is_zero;
			re_out <= zero_s1 ? sat32(gre) : sat32(sre);
			im_out <= zero_s1 ? sat32(gim) : sat32(sim);
		end
	end
endmodule

// ===== sv/phase_vocoder_bin_rotator.sv =====
// Phase vocoder bin rotator: channel handling, rotation memories, forwarding.
// Uses pvr_pkg, pvr_if, pvr_ram, pvr_sine, pvr_rotate and the macro header.
// Input channel "req" takes one bin request; output "rsp" returns one result.
// gain_we/gain_wdata load the Q1.31 gain; write it only while idle.
// Pipeline: 4 stages of sine evaluation (write to memory at stage 4),
// memory read at stage 4, one register, then 2 rotate stages, then output.
// Throughput is one request a cycle while rsp is not stalled, set by the
// single write and read port of each rotation memory.
// A request that refreshes its rotation uses the new values, forwarded past the memory.
// The whole pipeline advances only when the output register can take data,
// so a stall on rsp holds all stages and drops req.ready.
// Reset clears all valid bits and the gain; memory contents stay undefined
// until each bin is refreshed.
`timescale 1ns / 1ps
`include "phase_vocoder_bin_rotator_macros.svh"
module phase_vocoder_bin_rotator (
	input logic clk,
	input logic arst_n,
	pvr_in_if.sink req,
	pvr_out_if.source rsp,
	input logic gain_we,
	input logic [31:0] gain_wdata
);
	import pvr_pkg::*;
	localparam int Depth = 7;

	logic [31:0] gain_q;
	logic adv;
	logic [Depth-1:0] vld_q;
	pvr_in_t d_q [Depth];
	logic signed [23:0] ph, cph;
	logic signed [31:0] cos_w, sin_w, cos_r, sin_r, c_sel, s_sel, c_s5, s_s5;
	logic in_rng4, we4, fwd_q;
	logic signed [31:0] fc_q, fs_q;
	logic [AddrW-1:0] a4;

	assign adv = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gain_q <= '0;
		else if (gain_we) gain_q <= gain_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rsp.valid <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], req.valid};
			rsp.valid <= vld_q[Depth-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_q[0] <= req.data;
			for (int i = 1; i < Depth; i++) d_q[i] <= d_q[i-1];
		end
	end

	assign ph = req.data.phase_advance[23:0];
	assign cph = ph + Q24Quarter;

	pvr_sine u_cos (.clk, .en(adv), .phase(cph), .gain(gain_q), .rot(cos_w));
	pvr_sine u_sin (.clk, .en(adv), .phase(ph), .gain(gain_q), .rot(sin_w));

	// stage 4: d_q[3] has its rotation in cos_w/sin_w
	assign in_rng4 = 32'(d_q[3].bin_index) < Bins;
	assign a4 = AddrW'(d_q[3].bin_index);
	assign we4 = adv && vld_q[3] && d_q[3].refresh_rotation && in_rng4;

	pvr_ram #(.Width(32), .Depth(Bins)) u_cos_mem (.clk, .we(we4), .waddr(a4),
		.wdata(cos_w), .re(adv), .raddr(a4), .rdata(cos_r));
	pvr_ram #(.Width(32), .Depth(Bins)) u_sin_mem (.clk, .we(we4), .waddr(a4),
		.wdata(sin_w), .re(adv), .raddr(a4), .rdata(sin_r));

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_q <= d_q[3].refresh_rotation;
			fc_q <= cos_w;
			fs_q <= sin_w;
			c_s5 <= c_sel;
			s_s5 <= s_sel;
		end
	end

	// stage 5: d_q[4]; out-of-range bins read zero
	logic in_rng5;
	assign in_rng5 = 32'(d_q[4].bin_index) < Bins;
	assign c_sel = !in_rng5 ? '0 : (fwd_q ? fc_q : cos_r);
	assign s_sel = !in_rng5 ? '0 : (fwd_q ? fs_q : sin_r);

	pvr_rotate u_rot (.clk, .en(adv), .re_in(d_q[5].bin_real), .im_in(d_q[5].bin_imag),
		.c(c_s5), .s(s_s5), .gain(gain_q), .is_zero(d_q[5].bin_index == '0),
		.re_out(rsp.data.out_real), .im_out(rsp.data.out_imag));

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.data.phase_valid <= d_q[6].refresh_rotation;
			rsp.data.synth_phase <= d_q[6].refresh_rotation ?
				24'(d_q[6].analysis_phase + d_q[6].phase_advance) : '0;
		end
	end

	`PVR_ASSERT_IMPL(a_ready_when_free, !rsp.valid, req.ready)
	`PVR_ASSERT_NEXT(a_stall_holds, rsp.valid && !rsp.ready, rsp.valid)
	`PVR_ASSERT_IMPL(a_no_write_stalled, we4, adv)
endmodule
